// ===== rtl/at_ipd_frame_parser_top_assert.svh =====
// Assertion macros shared by the frame parser modules.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef AT_IPD_FRAME_PARSER_TOP_ASSERT_SVH
`define AT_IPD_FRAME_PARSER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define AT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AT_ASSERT_IMP(lbl, ante, cons, msg)
`define AT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/atipd_pkg.sv =====
package atipd_pkg;

    localparam int BUFFER_SIZE = 256;
    localparam int KEPT_W      = $clog2(BUFFER_SIZE);
    localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(BUFFER_SIZE - 1);

    // Command queue between the parser and the result stage.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] LIMIT_RESET = 8'd255;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Signature phases S0..S4 count the matched characters of "+IPD,".
    typedef enum logic [3:0] {
        PH_S0   = 4'd0,
        PH_S1   = 4'd1,
        PH_S2   = 4'd2,
        PH_S3   = 4'd3,
        PH_S4   = 4'd4,
        PH_ID   = 4'd5,
        PH_LEN  = 4'd6,
        PH_DATA = 4'd7,
        PH_DONE = 4'd8,
        PH_FAIL = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_reply;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] client_id;
        logic [7:0] payload_length;
        logic       parse_failed;
        logic       ok_seen;
        logic       last_result;
    } result_t;

    // One queued command per accepted byte that produces any result.
    typedef struct packed {
        logic       has_payload;
        logic [7:0] payload_byte;
        logic       has_summary;
        logic [7:0] client_id;
        logic [7:0] payload_length;
        logic       parse_failed;
        logic       ok_seen;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [7:0] sig_char(input phase_t p);
        logic [7:0] c;
        unique case (p)
            PH_S0:   c = CH_PLUS;
            PH_S1:   c = CH_I;
            PH_S2:   c = CH_P;
            PH_S3:   c = CH_D;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

// ===== rtl/atipd_front.sv =====
`include "at_ipd_frame_parser_top_assert.svh"

module atipd_front
    import atipd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  item_t      item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  qstat_t     qstat,
    output logic       cmd_wr,
    output cmd_t       cmd
);

    phase_t            phase_reg,      phase_next;
    logic [7:0]        id_reg,         id_next;
    logic [KEPT_W-1:0] kept_reg,       kept_next;
    logic [7:0]        pcount_reg,     pcount_next;
    logic              prev_o_reg,     prev_o_next;
    logic              ok_reg,         ok_next;
    logic [7:0]        limit_reg;

    logic       accept;
    logic [7:0] b;
    logic       ok_parse;

    assign cfg_ready = 1'b1;
    assign accept    = push && !qstat.full;
    assign b         = item.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_S0;
            id_reg     <= '0;
            kept_reg   <= '0;
            pcount_reg <= '0;
            prev_o_reg <= 1'b0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            kept_reg   <= kept_next;
            pcount_reg <= pcount_next;
            prev_o_reg <= prev_o_next;
            ok_reg     <= ok_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        kept_next   = kept_reg;
        pcount_next = pcount_reg;
        prev_o_next = prev_o_reg;
        ok_next     = ok_reg;
        cmd         = '0;
        ok_parse    = 1'b0;

        if (accept)
        begin
            // Bytes after the first KEPT_MAX of a reply leave the parse untouched.
            if (kept_reg < KEPT_MAX)
            begin
                kept_next = kept_reg + 1'b1;
                if (prev_o_reg && (b == CH_K))
                begin
                    ok_next = 1'b1;
                end
                prev_o_next = (b == CH_O);

                unique case (phase_reg) inside
                    PH_S0, PH_S1, PH_S2, PH_S3, PH_S4:
                    begin
                        if (b == sig_char(phase_reg))
                        begin
                            phase_next = phase_t'(phase_reg + 4'd1);
                        end
                        else
                        begin
                            phase_next = (b == CH_PLUS) ? PH_S1 : PH_S0;
                        end
                    end
                    PH_ID:
                    begin
                        if (is_digit(b))
                        begin
                            id_next = (id_reg << 3) + (id_reg << 1) + (b - CH_ZERO);
                        end
                        else
                        begin
                            phase_next = (b == CH_COMMA) ? PH_LEN : PH_FAIL;
                        end
                    end
                    PH_LEN:
                    begin
                        if (!is_digit(b))
                        begin
                            phase_next = (b == CH_COLON) ? PH_DATA : PH_FAIL;
                        end
                    end
                    PH_DATA:
                    begin
                        if ((b == CH_CR) || (b == CH_LF))
                        begin
                            phase_next = PH_DONE;
                        end
                        else if ((limit_reg != 8'd0) && (pcount_reg < (limit_reg - 8'd1)))
                        begin
                            pcount_next      = pcount_reg + 8'd1;
                            cmd.has_payload  = 1'b1;
                            cmd.payload_byte = b;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (item.end_of_reply)
            begin
                ok_parse = ((phase_next == PH_DATA) || (phase_next == PH_DONE))
                           && (limit_reg != 8'd0);
                cmd.has_summary    = 1'b1;
                cmd.client_id      = ok_parse ? id_next : 8'd0;
                cmd.payload_length = ok_parse ? pcount_next : 8'd0;
                cmd.parse_failed   = !ok_parse;
                cmd.ok_seen        = ok_next;

                phase_next  = PH_S0;
                id_next     = '0;
                kept_next   = '0;
                pcount_next = '0;
                prev_o_next = 1'b0;
                ok_next     = 1'b0;
            end
        end
    end

    assign cmd_wr = accept && (cmd.has_payload || cmd.has_summary);

    `AT_ASSERT_IMP(f_payload_in_data, cmd_wr && cmd.has_payload,
                   phase_reg == PH_DATA, "payload command outside the data phase")
    `AT_ASSERT_IMP(f_kept_bound, 1'b1, kept_reg <= KEPT_MAX,
                   "kept byte count past buffer capacity")

endmodule

// ===== rtl/atipd_queue.sv =====
`include "at_ipd_frame_parser_top_assert.svh"

module atipd_queue
    import atipd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  cmd_t   wr_cmd,
    input  logic   rd_en,
    output cmd_t   head,
    output qstat_t qstat
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign head        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    `AT_ASSERT_IMP(q_no_overflow, wr_en, !qstat.full, "command written into a full queue")
    `AT_ASSERT_IMP(q_no_underflow, rd_en, !qstat.empty, "command read from an empty queue")

endmodule

// ===== rtl/atipd_back.sv =====
`include "at_ipd_frame_parser_top_assert.svh"

module atipd_back
    import atipd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    head,
    input  qstat_t  qstat,
    output logic    rd_en,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    logic    out_valid_reg, out_valid_next;
    result_t result_reg,    result_next;
    logic    split_reg,     split_next;
    logic    load;

    assign load   = !out_valid_reg || pop;
    assign empty  = !out_valid_reg;
    assign result = result_reg;

    // A command carrying both a payload byte and a summary is sent in two
    // transfers; split_reg marks that its payload part has already gone out.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        split_next     = split_reg;
        rd_en          = 1'b0;

        if (load)
        begin
            out_valid_next = !qstat.empty;
            if (!qstat.empty)
            begin
                result_next = '0;
                if (head.has_payload && !split_reg)
                begin
                    result_next.kind         = KIND_PAYLOAD;
                    result_next.payload_byte = head.payload_byte;
                    if (head.has_summary)
                    begin
                        split_next = 1'b1;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
                else
                begin
                    result_next.kind           = KIND_SUMMARY;
                    result_next.client_id      = head.client_id;
                    result_next.payload_length = head.payload_length;
                    result_next.parse_failed   = head.parse_failed;
                    result_next.ok_seen        = head.ok_seen;
                    result_next.last_result    = 1'b1;
                    rd_en                      = 1'b1;
                    split_next                 = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            split_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            split_reg     <= split_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    `AT_ASSERT_IMP(b_split_held, split_reg, !qstat.empty && head.has_summary,
                   "split command left the queue early")
    `AT_ASSERT_IMP(b_split_payload_first, split_reg,
                   out_valid_reg && (result_reg.kind == KIND_PAYLOAD),
                   "summary shown before its payload byte")

endmodule

// ===== rtl/at_ipd_frame_parser_top.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------
// input    | in        | push / full          | item   (rx_byte, end_of_reply)
// result   | out       | pop / empty          | result (kind ... last_result)
// config   | in        | cfg_valid / cfg_ready| cfg_data (payload_limit)
//
// The parser takes one byte per cycle while full is low and posts at most one
// command per byte into a four-entry command queue; the result stage drains one
// result per cycle while pop is held, so a final byte that also closes out a
// payload byte gives two results. Each passes the queue, then the result register.
// Reset clears all parse state and sets payload_limit to 255; there is no
// clearing pass. full rises only when the command queue fills under pop stalls.

module at_ipd_frame_parser_top
    import atipd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  item_t      item,
    output logic       empty,
    input  logic       pop,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    qstat_t qstat;
    logic   cmd_wr;
    cmd_t   cmd;
    cmd_t   head;
    logic   rd_en;

    assign full = qstat.full;

    atipd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .cmd_wr    (cmd_wr),
        .cmd       (cmd)
    );

    atipd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_wr),
        .wr_cmd (cmd),
        .rd_en  (rd_en),
        .head   (head),
        .qstat  (qstat)
    );

    atipd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .rd_en  (rd_en),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

// ===== sim/at_ipd_frame_parser_top_tb.sv =====
`timescale 1ns / 1ps

module at_ipd_frame_parser_top_tb;
    import atipd_pkg::*;

    localparam int TOTAL_ITEMS = 1850;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        string      text;
        int         pad;
        logic [7:0] limit;
        bit         typed;
        result_t    summary;
    } reply_case_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    full;
    item_t   item = '0;
    logic    empty;
    logic    pop = 1'b0;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [7:0] cfg_data = 8'd0;

    // Parser state as the block should hold it.
    phase_t            phase = PH_S0;
    logic [7:0]        id_sum = 8'd0;
    logic [KEPT_W-1:0] kept = '0;
    logic [7:0]        emitted = 8'd0;
    logic              saw_o = 1'b0;
    logic              ok_text = 1'b0;
    logic [7:0]        payload_limit_now = LIMIT_RESET;
    logic [7:0]        ipd_sig [5] = '{CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA};

    result_t     pending_results[$];
    logic [7:0]  reply[$];
    reply_case_t cases[$];

    int  mismatches = 0;
    int  item_count = 0;
    int  cycle_count = 0;
    bit  push_steady = 1'b0;
    bit  pop_steady = 1'b0;
    int  pop_wait = 0;

    at_ipd_frame_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(12, 40);
    endfunction

    // Works out the results of one accepted byte and queues them.
    task automatic parse_reply_byte(input logic [7:0] b, input logic last);
        result_t r;
        logic    is_dec;
        logic    parsed;
        is_dec = (b >= CH_ZERO) && (b <= CH_NINE);
        if (kept < KEPT_MAX)
        begin
            kept = kept + 1'b1;
            if (saw_o && b == CH_K)
                ok_text = 1'b1;
            saw_o = (b == CH_O);
            if (phase <= PH_S4)
            begin
                if (b == ipd_sig[phase])
                    phase = (phase == PH_S4) ? PH_ID : phase_t'(phase + 4'd1);
                else
                    phase = (b == CH_PLUS) ? PH_S1 : PH_S0;
            end
            else if (phase == PH_ID)
            begin
                if (is_dec)
                    id_sum = 8'(id_sum * 8'd10 + (b - CH_ZERO));
                else
                    phase = (b == CH_COMMA) ? PH_LEN : PH_FAIL;
            end
            else if (phase == PH_LEN)
            begin
                if (!is_dec)
                    phase = (b == CH_COLON) ? PH_DATA : PH_FAIL;
            end
            else if (phase == PH_DATA)
            begin
                if (b == CH_CR || b == CH_LF)
                    phase = PH_DONE;
                else if (payload_limit_now != 8'd0 && emitted < payload_limit_now - 8'd1)
                begin
                    emitted = emitted + 8'd1;
                    r = '0;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = b;
                    pending_results.push_back(r);
                end
            end
        end
        if (last)
        begin
            parsed = (phase == PH_DATA || phase == PH_DONE) && payload_limit_now != 8'd0;
            r = '0;
            r.kind = KIND_SUMMARY;
            r.client_id = parsed ? id_sum : 8'd0;
            r.payload_length = parsed ? emitted : 8'd0;
            r.parse_failed = !parsed;
            r.ok_seen = ok_text;
            r.last_result = 1'b1;
            pending_results.push_back(r);
            phase = PH_S0;
            id_sum = 8'd0;
            kept = '0;
            emitted = 8'd0;
            saw_o = 1'b0;
            ok_text = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = push_steady ? 0 : random_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{rx_byte: b, end_of_reply: last};
        @(posedge clk);
        while (full) @(posedge clk);
        parse_reply_byte(b, last);
    endtask

    // Lets every result drain and the parser go quiet before a register write.
    task automatic settle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        payload_limit_now = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        else if (r == 1)
            return 8'd1;
        else if (r == 2)
            return 8'd2;
        else if (r == 3)
            return 8'($urandom_range(3, 20));
        else if (r == 4)
            return 8'd254;
        else if (r < 7)
            return 8'($urandom_range(0, 255));
        return 8'd255;
    endfunction

    // Mostly any byte, often one of the characters the parser reacts to.
    function automatic logic [7:0] reply_byte();
        string hot;
        hot = "+IPD,:09OK\015\012";
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 255));
        return hot[$urandom_range(0, hot.len() - 1)];
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            reply.push_back(s[i]);
    endtask

    task automatic build_reply();
        int style;
        int cut;
        int plen;
        reply.delete();
        style = $urandom_range(0, 99);
        if (style < 12)
        begin
            repeat ($urandom_range(1, 12)) reply.push_back(reply_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 2)) reply.push_back(reply_byte());
            if ($urandom_range(0, 5) == 0)
                push_text("+IP");
            push_text("+IPD,");
            repeat ($urandom_range(0, 4)) reply.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            reply.push_back((style >= 90 && style < 95) ? reply_byte() : CH_COMMA);
            repeat ($urandom_range(0, 3)) reply.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            reply.push_back((style >= 95) ? reply_byte() : CH_COLON);
            plen = ($urandom_range(0, 39) == 0) ? $urandom_range(240, 280)
                                                : $urandom_range(0, 16);
            repeat (plen) reply.push_back(reply_byte());
            if ($urandom_range(0, 1) == 1)
            begin
                reply.push_back(CH_CR);
                reply.push_back(CH_LF);
                if ($urandom_range(0, 2) == 0)
                    push_text("OK\015\012");
            end
            // Replies cut short somewhere in the frame.
            if (style >= 80 && style < 90)
            begin
                cut = $urandom_range(1, reply.size());
                while (reply.size() > cut)
                    void'(reply.pop_back());
            end
        end
    endtask

    // A split reply gets a new limit written partway through.
    task automatic send_reply(input bit split);
        int cut_at;
        cut_at = split ? $urandom_range(1, reply.size() - 1) : -1;
        foreach (reply[i])
        begin
            if (i == cut_at)
            begin
                settle();
                write_limit(pick_limit());
            end
            send_byte(reply[i], i == reply.size() - 1);
            if (i < KEPT_MAX)
                item_count++;
        end
    endtask

    task automatic add_case(input string text, input int pad, input logic [7:0] limit,
                            input bit typed, input logic [7:0] id, input logic [7:0] len,
                            input logic failed, input logic ok);
        reply_case_t rc;
        rc.text = text;
        rc.pad = pad;
        rc.limit = limit;
        rc.typed = typed;
        rc.summary = '{kind: KIND_SUMMARY, payload_byte: 8'd0, client_id: id,
                       payload_length: len, parse_failed: failed, ok_seen: ok,
                       last_result: 1'b1};
        cases.push_back(rc);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %p", result);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, result.kind);
                check_field("payload_byte", want.payload_byte, result.payload_byte);
                check_field("client_id", want.client_id, result.client_id);
                check_field("payload_length", want.payload_length, result.payload_length);
                check_field("parse_failed", want.parse_failed, result.parse_failed);
                check_field("ok_seen", want.ok_seen, result.ok_seen);
                check_field("last_result", want.last_result, result.last_result);
            end
        end
    end

    always @(posedge clk)
    begin
        int g;
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_wait != 0)
        begin
            pop <= 1'b0;
            pop_wait <= pop_wait - 1;
        end
        else if (pop_steady)
            pop <= 1'b1;
        else
        begin
            g = random_gap();
            pop <= (g == 0);
            pop_wait <= (g == 0) ? 0 : g - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("at_ipd_frame_parser_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        int  reply_count;
        bit  split;
        reply_count = 0;

        add_case("+IPD,0,5:hello\015\012OK\015\012", 0, 8'd255, 1, 8'd0, 8'd5, 1'b0, 1'b1);
        add_case("+IPD,255,3:abc", 0, 8'd255, 1, 8'd255, 8'd3, 1'b0, 1'b0);
        add_case("+IPD,256,1:z\012", 0, 8'd255, 1, 8'd0, 8'd1, 1'b0, 1'b0);
        add_case("+IPD,1000,2:ab", 0, 8'd255, 1, 8'd232, 8'd2, 1'b0, 1'b0);
        add_case("garbage OK", 0, 8'd255, 1, 8'd0, 8'd0, 1'b1, 1'b1);
        add_case("++IPD,7,2:", 0, 8'd255, 1, 8'd7, 8'd0, 1'b0, 1'b0);
        add_case("+IP+IPD,5,1:q\015", 0, 8'd255, 0, 8'd0, 8'd0, 1'b0, 1'b0);
        add_case("+IPD,,:", 0, 8'd255, 1, 8'd0, 8'd0, 1'b0, 1'b0);
        add_case("+IPD,12", 0, 8'd255, 1, 8'd0, 8'd0, 1'b1, 1'b0);
        add_case("+IPD,3,45", 0, 8'd255, 1, 8'd0, 8'd0, 1'b1, 1'b0);
        add_case("+IPD,3;4:xy", 0, 8'd255, 1, 8'd0, 8'd0, 1'b1, 1'b0);
        add_case("+IPD,3,4;+IPD,1,1:a", 0, 8'd255, 1, 8'd0, 8'd0, 1'b1, 1'b0);
        add_case("\012", 0, 8'd255, 1, 8'd0, 8'd0, 1'b1, 1'b0);
        add_case("+IPD,6,2:\377\200", 0, 8'd255, 1, 8'd6, 8'd2, 1'b0, 1'b0);
        add_case("+IPD,2,3:xyz\015\012OK", 0, 8'd255, 1, 8'd2, 8'd3, 1'b0, 1'b1);
        add_case("+IPD,1,2:ab\015\012", 0, 8'd0, 1, 8'd0, 8'd0, 1'b1, 1'b0);
        add_case("+IPD,9,2:ab\015\012", 0, 8'd1, 1, 8'd9, 8'd0, 1'b0, 1'b0);
        add_case("+IPD,9,5:abcde\015\012", 0, 8'd3, 1, 8'd9, 8'd2, 1'b0, 1'b0);
        add_case("+IPD,8,2:OK", 0, 8'd2, 0, 8'd0, 8'd0, 1'b0, 1'b0);
        // Runs past the buffer: only the first bytes count, the last mark still ends it.
        add_case("+IPD,4,300:", 260, 8'd255, 0, 8'd0, 8'd0, 1'b0, 1'b0);

        wait (rst_n);
        @(posedge clk);

        foreach (cases[c])
        begin
            if (cases[c].limit != payload_limit_now)
            begin
                settle();
                write_limit(cases[c].limit);
            end
            reply.delete();
            push_text(cases[c].text);
            repeat (cases[c].pad) reply.push_back(8'h78);
            send_reply(1'b0);
            // The summary of this reply was queued at the transfer just taken.
            if (cases[c].typed)
                pending_results[pending_results.size() - 1] = cases[c].summary;
        end

        while (item_count < TOTAL_ITEMS)
        begin
            if (reply_count % 12 == 0)
            begin
                push_steady = ($urandom_range(0, 3) == 0);
                pop_steady <= ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1) == 1)
                begin
                    settle();
                    write_limit(pick_limit());
                end
            end
            build_reply();
            split = (reply.size() > 1) && ($urandom_range(0, 19) == 0);
            send_reply(split);
            reply_count++;
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("at_ipd_frame_parser_top: match");
        else
            $display("at_ipd_frame_parser_top: mismatch");
        $finish;
    end

endmodule
